// ===== src/b2d_pkg.sv =====
// Shared constants, types and handoff structs of the binary to decimal digit formatter.
package b2d_pkg;

   localparam int SHORT_DIGITS = 5;
   localparam int LONG_DIGITS  = 19;
   localparam int VALUE_W      = 64;
   localparam int SHORT_W      = 16;
   localparam int DIGIT_W      = 4;
   localparam int POS_W        = 5;
   localparam int NIBBLE_W     = 4;
   localparam int LONG_STEPS   = VALUE_W / NIBBLE_W;
   localparam int SHORT_STEPS  = SHORT_W / NIBBLE_W;
   localparam int STEP_W       = $clog2(LONG_STEPS + 1);
   localparam int SHORT_OFFSET = LONG_DIGITS - SHORT_DIGITS;

   typedef logic [DIGIT_W-1:0]         digit_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [NIBBLE_W-1:0]        nibble_type;
   typedef digit_type [LONG_DIGITS-1:0] row_type;

   localparam logic [VALUE_W-1:0] LONG_MAX        = 64'd9999999999999999999;
   localparam logic [SHORT_W-1:0] SHORT_ALL_BLANK = 16'hFFFF;
   localparam digit_type          BLANK_CODE      = 4'd10;
   localparam digit_type          ZERO_CODE       = 4'd0;
   localparam digit_type          ADJ_LIMIT       = 4'd5;
   localparam digit_type          ADJ_ADD         = 4'd3;
   localparam pos_type            LONG_LAST       = pos_type'(LONG_DIGITS - 1);
   localparam pos_type            SHORT_LAST      = pos_type'(SHORT_DIGITS - 1);

   typedef struct packed {
      row_type digits;
      logic    is_long;
      logic    align_left;
      logic    zero_fill;
      logic    all_blank;
   } conv_word_type;

   typedef struct packed {
      logic          valid;
      conv_word_type word;
   } conv_out_type;

endpackage

// ===== src/b2d_bcd_cell.sv =====
// One decimal digit of the shift-and-add-3 conversion chain, four bits per cycle while stepped.
module b2d_bcd_cell (
   input  logic                clock,
   input  logic                clear,
   input  logic                step,
   input  b2d_pkg::nibble_type bits_in,
   output b2d_pkg::nibble_type bits_out,
   output b2d_pkg::digit_type  digit
);

   b2d_pkg::digit_type digit_ff;
   b2d_pkg::digit_type digit_in;
   b2d_pkg::digit_type work;

   // Four adjust-and-shift rounds; bit 3 of the nibble enters first.
   always_comb begin
      work     = digit_ff;
      bits_out = '0;
      for (int k = b2d_pkg::NIBBLE_W - 1; k >= 0; k--) begin
         if (work >= b2d_pkg::ADJ_LIMIT) begin
            work = work + b2d_pkg::ADJ_ADD;
         end
         bits_out[k] = work[b2d_pkg::DIGIT_W-1];
         work        = {work[b2d_pkg::DIGIT_W-2:0], bits_in[k]};
      end
   end

   always_comb begin
      if (clear) begin
         digit_in = b2d_pkg::ZERO_CODE;
      end else if (step) begin
         digit_in = work;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

// ===== src/b2d_digit_cell.sv =====
// One digit slot of a shift chain that loads in parallel and moves toward the top.
module b2d_digit_cell (
   input  logic               clock,
   input  logic               load,
   input  b2d_pkg::digit_type load_digit,
   input  logic               shift,
   input  b2d_pkg::digit_type shift_in,
   output b2d_pkg::digit_type digit
);

   b2d_pkg::digit_type digit_ff;
   b2d_pkg::digit_type digit_in;

   always_comb begin
      if (load) begin
         digit_in = load_digit;
      end else if (shift) begin
         digit_in = shift_in;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

// ===== src/b2d_conv.sv =====
// Input stage: clamp or mask the value, then convert it to decimal digits in a cell chain.
module b2d_conv (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [b2d_pkg::VALUE_W-1:0]         req_value,
   input  logic                                req_align_left,
   input  logic                                req_zero_fill,
   output b2d_pkg::conv_out_type               conv_out,
   input  logic                                conv_take
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   b2d_pkg::step_type           steps_ff, steps_in;
   logic [b2d_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        is_long_ff, is_long_in;
   logic                        left_ff, left_in;
   logic                        fill_ff, fill_in;
   logic                        blank_ff, blank_in;
   logic                        accept;
   logic                        running;
   b2d_pkg::nibble_type         carry [b2d_pkg::LONG_DIGITS+1];
   b2d_pkg::row_type            digits;

   assign running   = busy_ff & ~done_ff;
   assign req_stall = busy_ff & ~(done_ff & conv_take);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      steps_in   = steps_ff;
      value_in   = value_ff;
      is_long_in = is_long_ff;
      left_in    = left_ff;
      fill_in    = fill_ff;
      blank_in   = blank_ff;
      if (running) begin
         value_in = value_ff << b2d_pkg::NIBBLE_W;
         steps_in = steps_ff - b2d_pkg::step_type'(1);
         if (steps_ff == b2d_pkg::step_type'(1)) begin
            done_in = 1'b1;
         end
      end
      if (done_ff && conv_take) begin
         busy_in = 1'b0;
         done_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         if (req_kind) begin
            value_in = (req_value > b2d_pkg::LONG_MAX) ? b2d_pkg::LONG_MAX : req_value;
            steps_in = b2d_pkg::step_type'(b2d_pkg::LONG_STEPS);
         end else begin
            value_in = {req_value[b2d_pkg::SHORT_W-1:0],
                        {(b2d_pkg::VALUE_W - b2d_pkg::SHORT_W){1'b0}}};
            steps_in = b2d_pkg::step_type'(b2d_pkg::SHORT_STEPS);
         end
         is_long_in = req_kind;
         left_in    = req_align_left;
         fill_in    = req_zero_fill;
         blank_in   = ~req_kind &
                      (req_value[b2d_pkg::SHORT_W-1:0] == b2d_pkg::SHORT_ALL_BLANK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff   <= steps_in;
      value_ff   <= value_in;
      is_long_ff <= is_long_in;
      left_ff    <= left_in;
      fill_ff    <= fill_in;
      blank_ff   <= blank_in;
   end

   // Feed the top nibble into the least significant digit; carries ripple upward.
   assign carry[0] = value_ff[b2d_pkg::VALUE_W-1 -: b2d_pkg::NIBBLE_W];

   for (genvar j = 0; j < b2d_pkg::LONG_DIGITS; j++) begin : g_cell
      b2d_bcd_cell u_cell (
         .clock    (clock),
         .clear    (accept),
         .step     (running),
         .bits_in  (carry[j]),
         .bits_out (carry[j+1]),
         .digit    (digits[j])
      );
   end

   assign conv_out.valid           = done_ff;
   assign conv_out.word.digits     = digits;
   assign conv_out.word.is_long    = is_long_ff;
   assign conv_out.word.align_left = left_ff;
   assign conv_out.word.zero_fill  = fill_ff;
   assign conv_out.word.all_blank  = blank_ff;

endmodule

// ===== src/b2d_fmt.sv =====
// Leading-zero strip chain and digit emitter chain with the result register.
module b2d_fmt (
   input  logic                  clock,
   input  logic                  reset,
   input  b2d_pkg::conv_out_type conv_out,
   output logic                  conv_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b2d_pkg::digit_type    rsp_digit_code,
   output b2d_pkg::pos_type      rsp_position,
   output logic                  rsp_last
);

   // Strip stage
   logic               norm_busy_ff, norm_busy_in;
   logic               norm_done_ff, norm_done_in;
   b2d_pkg::pos_type   norm_lz_ff, norm_lz_in;
   logic               norm_long_ff, norm_long_in;
   logic               norm_left_ff, norm_left_in;
   logic               norm_fill_ff, norm_fill_in;
   logic               norm_blank_ff, norm_blank_in;
   logic               norm_running;
   logic               norm_shift;
   logic               norm_give;
   b2d_pkg::row_type   norm_load_row;
   b2d_pkg::row_type   norm_row;

   // Emit stage
   logic               emit_busy_ff, emit_busy_in;
   b2d_pkg::pos_type   emit_pos_ff, emit_pos_in;
   b2d_pkg::pos_type   emit_lz_ff, emit_lz_in;
   b2d_pkg::pos_type   emit_nsig_ff, emit_nsig_in;
   logic               emit_long_ff, emit_long_in;
   logic               emit_left_ff, emit_left_in;
   logic               emit_fill_ff, emit_fill_in;
   logic               emit_blank_ff, emit_blank_in;
   logic               emit_step;
   logic               emit_is_last;
   logic               emit_free;
   logic               emit_show;
   logic               emit_advance;
   b2d_pkg::pos_type   emit_last_pos;
   b2d_pkg::pos_type   emit_cnt;
   b2d_pkg::digit_type emit_code;
   b2d_pkg::row_type   emit_row;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   b2d_pkg::digit_type rsp_code_ff, rsp_code_in;
   b2d_pkg::pos_type   rsp_pos_ff, rsp_pos_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;

   // ---------------- strip stage ----------------
   assign norm_running = norm_busy_ff & ~norm_done_ff;
   assign norm_shift   = norm_running & (norm_row[b2d_pkg::LONG_DIGITS-1] == b2d_pkg::ZERO_CODE)
                         & (norm_lz_ff != b2d_pkg::LONG_LAST);
   assign norm_give    = norm_done_ff & emit_free;
   assign conv_take    = conv_out.valid & (~norm_busy_ff | norm_give);

   // A short value sits in the low five digits: lift it straight to the top.
   assign norm_load_row = conv_out.word.is_long ? conv_out.word.digits :
      b2d_pkg::row_type'(conv_out.word.digits << (b2d_pkg::SHORT_OFFSET * b2d_pkg::DIGIT_W));

   always_comb begin
      norm_busy_in  = norm_busy_ff;
      norm_done_in  = norm_done_ff;
      norm_lz_in    = norm_lz_ff;
      norm_long_in  = norm_long_ff;
      norm_left_in  = norm_left_ff;
      norm_fill_in  = norm_fill_ff;
      norm_blank_in = norm_blank_ff;
      if (norm_running) begin
         if (norm_shift) begin
            norm_lz_in = norm_lz_ff + b2d_pkg::pos_type'(1);
         end else begin
            norm_done_in = 1'b1;
         end
      end
      if (norm_give) begin
         norm_busy_in = 1'b0;
         norm_done_in = 1'b0;
      end
      if (conv_take) begin
         norm_busy_in  = 1'b1;
         norm_done_in  = 1'b0;
         norm_lz_in    = conv_out.word.is_long ? '0 :
                         b2d_pkg::pos_type'(b2d_pkg::SHORT_OFFSET);
         norm_long_in  = conv_out.word.is_long;
         norm_left_in  = conv_out.word.align_left;
         norm_fill_in  = conv_out.word.zero_fill;
         norm_blank_in = conv_out.word.all_blank;
      end
   end

   for (genvar j = 0; j < b2d_pkg::LONG_DIGITS; j++) begin : g_norm
      if (j == 0) begin : g_bottom
         b2d_digit_cell u_cell (
            .clock      (clock),
            .load       (conv_take),
            .load_digit (norm_load_row[j]),
            .shift      (norm_shift),
            .shift_in   (b2d_pkg::ZERO_CODE),
            .digit      (norm_row[j])
         );
      end else begin : g_upper
         b2d_digit_cell u_cell (
            .clock      (clock),
            .load       (conv_take),
            .load_digit (norm_load_row[j]),
            .shift      (norm_shift),
            .shift_in   (norm_row[j-1]),
            .digit      (norm_row[j])
         );
      end
   end

   // ---------------- emit stage ----------------
   assign out_free      = ~rsp_valid_ff | ~rsp_stall;
   assign emit_step     = emit_busy_ff & out_free;
   assign emit_last_pos = emit_long_ff ? b2d_pkg::LONG_LAST : b2d_pkg::SHORT_LAST;
   assign emit_is_last  = (emit_pos_ff == emit_last_pos);
   assign emit_free     = ~emit_busy_ff | (emit_step & emit_is_last);
   assign emit_cnt      = norm_long_ff ? b2d_pkg::pos_type'(b2d_pkg::LONG_DIGITS) :
                          b2d_pkg::pos_type'(b2d_pkg::SHORT_DIGITS);

   always_comb begin
      emit_show = 1'b0;
      if (!emit_blank_ff) begin
         if (emit_left_ff) begin
            emit_show = (emit_pos_ff < emit_nsig_ff);
         end else begin
            emit_show = (emit_pos_ff >= emit_lz_ff);
         end
      end
      if (emit_show) begin
         emit_code = emit_row[b2d_pkg::LONG_DIGITS-1];
      end else if (emit_fill_ff) begin
         emit_code = b2d_pkg::ZERO_CODE;
      end else begin
         emit_code = b2d_pkg::BLANK_CODE;
      end
   end

   assign emit_advance = emit_step & emit_show;

   always_comb begin
      emit_busy_in  = emit_busy_ff;
      emit_pos_in   = emit_pos_ff;
      emit_lz_in    = emit_lz_ff;
      emit_nsig_in  = emit_nsig_ff;
      emit_long_in  = emit_long_ff;
      emit_left_in  = emit_left_ff;
      emit_fill_in  = emit_fill_ff;
      emit_blank_in = emit_blank_ff;
      if (emit_step) begin
         emit_pos_in = emit_pos_ff + b2d_pkg::pos_type'(1);
         if (emit_is_last) begin
            emit_busy_in = 1'b0;
         end
      end
      if (norm_give) begin
         emit_busy_in  = 1'b1;
         emit_pos_in   = '0;
         emit_lz_in    = norm_long_ff ? norm_lz_ff :
                         norm_lz_ff - b2d_pkg::pos_type'(b2d_pkg::SHORT_OFFSET);
         emit_nsig_in  = emit_cnt - emit_lz_in;
         emit_long_in  = norm_long_ff;
         emit_left_in  = norm_left_ff;
         emit_fill_in  = norm_fill_ff;
         emit_blank_in = norm_blank_ff;
      end
   end

   for (genvar j = 0; j < b2d_pkg::LONG_DIGITS; j++) begin : g_emit
      if (j == 0) begin : g_bottom
         b2d_digit_cell u_cell (
            .clock      (clock),
            .load       (norm_give),
            .load_digit (norm_row[j]),
            .shift      (emit_advance),
            .shift_in   (b2d_pkg::ZERO_CODE),
            .digit      (emit_row[j])
         );
      end else begin : g_upper
         b2d_digit_cell u_cell (
            .clock      (clock),
            .load       (norm_give),
            .load_digit (norm_row[j]),
            .shift      (emit_advance),
            .shift_in   (emit_row[j-1]),
            .digit      (emit_row[j])
         );
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_step) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = emit_code;
         rsp_pos_in   = emit_pos_ff;
         rsp_last_in  = emit_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_busy_ff <= 1'b0;
         norm_done_ff <= 1'b0;
         emit_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         norm_busy_ff <= norm_busy_in;
         norm_done_ff <= norm_done_in;
         emit_busy_ff <= emit_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_lz_ff    <= norm_lz_in;
      norm_long_ff  <= norm_long_in;
      norm_left_ff  <= norm_left_in;
      norm_fill_ff  <= norm_fill_in;
      norm_blank_ff <= norm_blank_in;
      emit_pos_ff   <= emit_pos_in;
      emit_lz_ff    <= emit_lz_in;
      emit_nsig_ff  <= emit_nsig_in;
      emit_long_ff  <= emit_long_in;
      emit_left_ff  <= emit_left_in;
      emit_fill_ff  <= emit_fill_in;
      emit_blank_ff <= emit_blank_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_code = rsp_code_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== src/binary_to_decimal_digit_formatter.sv =====
// Top level of the binary to decimal digit formatter: converter, strip and emit stages.
// Leading zero digits stripped from a word: 0..18 for a 64-bit word, 0..4 for a 16-bit one.
// The emit chain sets the pace: one digit word per cycle unless the receiver stalls.
// Reset (synchronous, active high) clears the stage control flags and the result valid;
//   digit chains and payload registers are left as they are and reload with each word.
module binary_to_decimal_digit_formatter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [b2d_pkg::VALUE_W-1:0] req_value,
   input  logic                        req_align_left,
   input  logic                        req_zero_fill,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output b2d_pkg::digit_type          rsp_digit_code,
   output b2d_pkg::pos_type            rsp_position,
   output logic                        rsp_last
);

   // Handoff from the converter to the strip stage: digits plus format flags.
   b2d_pkg::conv_out_type conv_out;
   logic                  conv_take;

   // Converter: clamp a long value to nineteen nines, mask a short one to 16 bits and
   // flag the all-ones short value, then run the shift-and-add-3 chain four bits a
   // cycle. Hold the digits until the strip stage takes them; a new word enters
   // on that same cycle.
   b2d_conv u_conv (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_align_left (req_align_left),
      .req_zero_fill  (req_zero_fill),
      .conv_out       (conv_out),
      .conv_take      (conv_take)
   );

   // Strip and emit: shift leading zero digits out of the top one per cycle and count
   // them (never past the last position), then walk the positions from the most
   // significant end. Right-aligned output shows blanks for the counted zeros before
   // the digits; left-aligned output shows the digits first and blanks after. Zero
   // fill turns each blank into digit 0. The result register holds a stalled digit
   // word; the emitter waits while the receiver stalls.
   b2d_fmt u_fmt (
      .clock          (clock),
      .reset          (reset),
      .conv_out       (conv_out),
      .conv_take      (conv_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_code (rsp_digit_code),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== src/b2d_checker.sv =====
// Port-level checks on the digit word stream of the formatter, bound to the top level.
module b2d_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input b2d_pkg::digit_type          rsp_digit_code,
   input b2d_pkg::pos_type            rsp_position,
   input logic                        rsp_last
);

   // Hold a stalled digit word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_code)
         && $stable(rsp_position) && $stable(rsp_last))
      else $error("stalled digit word changed");

   // Advance one position right after a taken word that is not the last.
   a_pos_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && (rsp_position == $past(rsp_position) + b2d_pkg::pos_type'(1)))
      else $error("digit positions not contiguous");

   // Close a value only at the final position of one of the two widths.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_position == b2d_pkg::SHORT_LAST) || (rsp_position == b2d_pkg::LONG_LAST))
      else $error("last flag on a wrong position");

   // Start the next value at position zero.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid || (rsp_position == '0))
      else $error("next value does not start at position zero");

   // Keep a valid code: a decimal digit or the blank code.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_code <= b2d_pkg::BLANK_CODE))
      else $error("digit code out of range");

endmodule

bind binary_to_decimal_digit_formatter b2d_checker u_b2d_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_code (rsp_digit_code),
   .rsp_position   (rsp_position),
   .rsp_last       (rsp_last)
);
